@@ hdl/scta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_pkg: shared types and constants of the scan code to ASCII FIFO
// Request codes, set 1 key numbers and the US layout translation tables.
// ----------------------------------------------------------------------------
package scta_pkg;

  typedef enum logic [1:0] {
    REQ_SCAN = 2'd0,
    REQ_POP  = 2'd1,
    REQ_FLAG = 2'd2
  } req_type_e;

  localparam logic [7:0] KEY_RELEASE = 8'h80;
  localparam logic [6:0] KEY_MASK    = 7'h7F;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_CAPS    = 7'h3A;
  localparam logic [6:0] KEY_C       = 7'h2E;
  localparam logic [7:0] CODE_BREAK  = 8'h03;
  localparam int unsigned MAP_LEN    = 59;
  localparam logic [7:0] FILL_MAX    = 8'hFF;

  localparam logic [7:0] MAP_PLAIN [MAP_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [7:0] MAP_UPPER [MAP_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  // Push request from the key decoder to the character store.
  typedef struct packed {
    logic       push;
    logic [7:0] ch;
  } push_t;

  // Store status seen by the result stage.
  typedef struct packed {
    logic       has_char;
    logic [7:0] fill;
  } store_stat_t;

  // Translate a key number; keys past the table give zero.
  function automatic logic [7:0] map_char(input logic [6:0] key, input logic upper);
    logic [7:0] ch;
    ch = 8'h00;
    if (key < 7'(MAP_LEN)) begin
      ch = upper ? MAP_UPPER[key[5:0]] : MAP_PLAIN[key[5:0]];
    end
    return ch;
  endfunction

endpackage

@@ hdl/scta_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_if: request and result channel interfaces
// Valid/ready channels carrying the request item and the result item.
// ----------------------------------------------------------------------------
interface scta_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] scan_code;

  modport source (output valid, output req_type, output scan_code, input ready);
  modport sink   (input valid, input req_type, input scan_code, output ready);
endinterface

interface scta_rsp_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;
  logic       break_seen;
  logic [7:0] fill_level;

  modport source (output valid, output char_valid, output char_code,
                  output break_seen, output fill_level, input ready);
  modport sink   (input valid, input char_valid, input char_code,
                  input break_seen, input fill_level, output ready);
endinterface

@@ hdl/scta_keymap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_keymap: modifier tracking and key translation
// Holds shift, ctrl, caps lock and the Ctrl+C flag; turns presses into pushes.
// ----------------------------------------------------------------------------
module scta_keymap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        scan_code_i,
  output scta_pkg::push_t   push_o,
  output logic              break_seen_o
);

  logic       shift_q, shift_d;
  logic       caps_q, caps_d;
  logic       ctrl_q, ctrl_d;
  logic       break_q, break_d;
  logic       rel;
  logic [6:0] key;

  assign rel = |(scan_code_i & scta_pkg::KEY_RELEASE);
  assign key = scan_code_i[6:0] & scta_pkg::KEY_MASK;

  always_comb begin
    shift_d      = shift_q;
    caps_d       = caps_q;
    ctrl_d       = ctrl_q;
    break_d      = break_q;
    push_o       = '0;
    break_seen_o = 1'b0;
    case (scta_pkg::req_type_e'(req_type_i))
      scta_pkg::REQ_SCAN: begin
        if (key == scta_pkg::KEY_LSHIFT || key == scta_pkg::KEY_RSHIFT) begin
          shift_d = !rel;
        end else if (key == scta_pkg::KEY_CTRL) begin
          ctrl_d = !rel;
        end else if (!rel) begin
          if (key == scta_pkg::KEY_CAPS) begin
            caps_d = !caps_q;
          end else if (ctrl_q && key == scta_pkg::KEY_C) begin
            break_d     = 1'b1;
            push_o.push = 1'b1;
            push_o.ch   = scta_pkg::CODE_BREAK;
          end else begin
            push_o.ch   = scta_pkg::map_char(key, shift_q ^ caps_q);
            push_o.push = |push_o.ch;
          end
        end
      end
      scta_pkg::REQ_FLAG: begin
        break_seen_o = break_q;
        break_d      = 1'b0;
      end
      default: begin
      end
    endcase
    // Gate the push on a real handshake.
    if (!accept_i) begin
      push_o.push = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
      ctrl_q  <= 1'b0;
      break_q <= 1'b0;
    end else if (accept_i) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
      ctrl_q  <= ctrl_d;
      break_q <= break_d;
    end
  end

endmodule

@@ hdl/scta_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_store: character ring buffer
// One synchronous memory with write and read pointers; read data registered.
// ----------------------------------------------------------------------------
module scta_store #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scta_pkg::push_t       push_i,
  input  logic                  pop_i,
  output scta_pkg::store_stat_t stat_o,
  output logic [7:0]            rd_data_o
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [AW-1:0] wp_inc, rp_inc;
  logic          full, we, re;
  logic [CW-1:0] cnt;
  logic [7:0]    rd_data_q;

  assign wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
  assign full   = (wp_inc == rp_q);

  assign stat_o.has_char = (wp_q != rp_q);
  assign we = push_i.push && !full;
  assign re = pop_i && stat_o.has_char;

  assign wp_d = we ? wp_inc : wp_q;
  assign rp_d = re ? rp_inc : rp_q;

  // Fill level after the current item, clipped to the 8-bit field.
  always_comb begin
    if (wp_d >= rp_d) begin
      cnt = CW'(wp_d) - CW'(rp_d);
    end else begin
      cnt = CW'(wp_d) + CW'(FIFO_DEPTH) - CW'(rp_d);
    end
    stat_o.fill = (cnt > CW'(scta_pkg::FILL_MAX)) ? scta_pkg::FILL_MAX : cnt[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  // Pushes never land on an unread entry, and one item is taken per cycle,
  // so a read and a write never target the same entry in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= push_i.ch;
    end
    if (re) begin
      rd_data_q <= mem[rp_q];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/scancode_to_ascii_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo: set 1 scan code to ASCII converter with FIFO
// Keyboard decoder feeding a character ring buffer, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: a scan code (req_type 0), a character pop
//   (req_type 1) or a read-and-clear of the Ctrl+C flag (req_type 2).
//   rsp_o returns exactly one result per request, in order: the popped
//   character (char_valid/char_code), the flag (break_seen) and the FIFO
//   fill level after the request.
// Timing:
//   The acceptance edge loads the read stage and the character memory read
//   register; the output register takes both once it is free or draining,
//   and the result is on rsp_o from that register until it is taken.
//   One request per cycle is sustained while rsp_o.ready is high; the limit
//   is the single memory port pair.
// Reset:
//   rst_ni clears the pointers, the modifier keys, caps lock, the flag and
//   the pipeline valids. The memory contents are not cleared; only written
//   entries are ever read.
// Stall:
//   With rsp_o.ready low the output register holds its result and one more
//   request may still be taken into the read stage; after that req_i.ready
//   drops until the output drains.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scta_req_if.sink   req_i,
  scta_rsp_if.source rsp_o
);

  logic                  accept;
  logic                  pop_req;
  scta_pkg::push_t       push;
  logic                  seen;
  scta_pkg::store_stat_t stat;
  logic [7:0]            rd_data;

  // Read stage: waits for the memory data of a pop.
  logic       s1_valid_q;
  logic       s1_hit_q;
  logic       s1_seen_q;
  logic [7:0] s1_fill_q;
  logic       s1_move;

  // Output register.
  logic       out_valid_q;
  logic       out_hit_q;
  logic [7:0] out_code_q;
  logic       out_seen_q;
  logic [7:0] out_fill_q;

  // Advance the read stage when the output register is free or draining.
  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_move;
  assign accept      = req_i.valid && req_i.ready;
  assign pop_req     = accept &&
                       (scta_pkg::req_type_e'(req_i.req_type) == scta_pkg::REQ_POP);

  scta_keymap u_keymap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_i.req_type),
    .scan_code_i  (req_i.scan_code),
    .push_o       (push),
    .break_seen_o (seen)
  );

  scta_store #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop_req),
    .stat_o    (stat),
    .rd_data_o (rd_data)
  );

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture request results, then merge in the memory data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hit_q  <= pop_req && stat.has_char;
      s1_seen_q <= seen;
      s1_fill_q <= stat.fill;
    end
    if (s1_move) begin
      out_hit_q  <= s1_hit_q;
      out_code_q <= s1_hit_q ? rd_data : 8'h00;
      out_seen_q <= s1_seen_q;
      out_fill_q <= s1_fill_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.char_valid = out_hit_q;
  assign rsp_o.char_code  = out_code_q;
  assign rsp_o.break_seen = out_seen_q;
  assign rsp_o.fill_level = out_fill_q;

endmodule

@@ hdl/scta_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_checker: port-level checks of the scan code to ASCII FIFO
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module scta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       char_valid_i,
  input logic [7:0] char_code_i,
  input logic       break_seen_i,
  input logic [7:0] fill_level_i
);

  // An empty or non-pop result carries a zero character.
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !char_valid_i |-> char_code_i == 8'h00)
    else $error("char_code nonzero without char_valid");

  // A result never carries both a popped character and a set flag.
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(char_valid_i && break_seen_i))
    else $error("char_valid and break_seen both set");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(char_valid_i) &&
      $stable(char_code_i) && $stable(break_seen_i) && $stable(fill_level_i))
    else $error("result changed while stalled");

endmodule

bind scancode_to_ascii_fifo scta_checker u_scta_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .char_valid_i (rsp_o.char_valid),
  .char_code_i  (rsp_o.char_code),
  .break_seen_i (rsp_o.break_seen),
  .fill_level_i (rsp_o.fill_level)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for scancode_to_ascii_fifo
// Drives scan code, pop and flag requests through the valid/ready request
// channel with random gaps and output stalls. A behavioral keyboard model
// (modifier state, caps lock, US layout tables, ring FIFO, break flag)
// predicts each result, and every result is compared in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RST_CYCLES  = 7;
  localparam int unsigned FIFO_DEPTH  = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_WAIT   = 8;
  localparam int unsigned MAX_REPORTS = 10;

  // Request type the block must treat as a no-op.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Set 1 key numbers and codes the keyboard model acts on.
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_C       = 7'h2E;
  localparam logic [7:0] BREAK_CHAR = 8'h03;
  localparam int unsigned TBL_LEN   = 59;

  // US layout, unshifted and shifted; zero marks a key that types nothing.
  localparam logic [7:0] plain_keys [TBL_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [7:0] shifted_keys [TBL_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic       break_seen;
    logic [7:0] fill_level;
  } char_rsp_t;

  localparam char_rsp_t IDLE_RSP = '0;

  // One directed request; typed rows carry their own expected result.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       typed;
    char_rsp_t  rsp;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 26;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{scta_pkg::REQ_POP,  8'h00, 1'b1, IDLE_RSP},  // pop right after reset: empty
    '{scta_pkg::REQ_FLAG, 8'h00, 1'b1, IDLE_RSP},  // flag right after reset: clear
    '{REQ_NONE,           8'hFF, 1'b1, IDLE_RSP},  // unused request type: no-op
    '{scta_pkg::REQ_SCAN, 8'h00, 1'b1, IDLE_RSP},  // key 0 has no character
    '{scta_pkg::REQ_SCAN, 8'h9E, 1'b1, IDLE_RSP},  // release of a plain key: ignored
    '{scta_pkg::REQ_SCAN, 8'h1E, 1'b0, IDLE_RSP},  // 'a'
    '{scta_pkg::REQ_SCAN, 8'h2A, 1'b0, IDLE_RSP},  // left shift down
    '{scta_pkg::REQ_SCAN, 8'h1E, 1'b0, IDLE_RSP},  // 'A'
    '{scta_pkg::REQ_SCAN, 8'hAA, 1'b0, IDLE_RSP},  // left shift up
    '{scta_pkg::REQ_SCAN, 8'h3A, 1'b0, IDLE_RSP},  // caps lock on
    '{scta_pkg::REQ_SCAN, 8'hBA, 1'b0, IDLE_RSP},  // caps lock release: no toggle
    '{scta_pkg::REQ_SCAN, 8'h02, 1'b0, IDLE_RSP},  // caps alone picks the shifted table
    '{scta_pkg::REQ_SCAN, 8'h36, 1'b0, IDLE_RSP},  // right shift down with caps on
    '{scta_pkg::REQ_SCAN, 8'h10, 1'b0, IDLE_RSP},  // shift and caps cancel: 'q'
    '{scta_pkg::REQ_SCAN, 8'hB6, 1'b0, IDLE_RSP},  // right shift up
    '{scta_pkg::REQ_SCAN, 8'h3A, 1'b0, IDLE_RSP},  // caps lock off
    '{scta_pkg::REQ_SCAN, 8'h1D, 1'b0, IDLE_RSP},  // ctrl down
    '{scta_pkg::REQ_SCAN, 8'h2E, 1'b0, IDLE_RSP},  // Ctrl+C: break char and flag
    '{scta_pkg::REQ_SCAN, 8'h1F, 1'b0, IDLE_RSP},  // ctrl with another key: 's'
    '{scta_pkg::REQ_SCAN, 8'h9D, 1'b0, IDLE_RSP},  // ctrl up
    '{scta_pkg::REQ_SCAN, 8'hE0, 1'b0, IDLE_RSP},  // extended prefix: nothing
    '{scta_pkg::REQ_SCAN, 8'h3B, 1'b0, IDLE_RSP},  // first key past the table
    '{scta_pkg::REQ_SCAN, 8'h39, 1'b0, IDLE_RSP},  // space
    '{scta_pkg::REQ_FLAG, 8'h00, 1'b0, IDLE_RSP},  // flag read returns the break
    '{scta_pkg::REQ_FLAG, 8'h00, 1'b0, IDLE_RSP},  // and clears it
    '{scta_pkg::REQ_POP,  8'h00, 1'b0, IDLE_RSP}   // oldest character
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  scta_req_if req_bus ();
  scta_rsp_if rsp_bus ();

  scancode_to_ascii_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus.sink),
    .rsp_o (rsp_bus.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Keyboard model state.
  logic [7:0]  kbd_mem [FIFO_DEPTH];
  int unsigned wr_idx, rd_idx;
  logic        shift_dn, caps_tog, ctrl_dn, brk_flag;

  // Results owed by the block, oldest first.
  char_rsp_t   kbd_rsp_due [$];

  int unsigned sent_cnt, fault_cnt, cycle_cnt;
  int unsigned popped_cnt, empty_pop_cnt, dropped_cnt, breaks_read_cnt;
  int unsigned gap_run, hold_left, mode_left;
  bit          src_gappy, sink_stalls, quiet_tail;

  function automatic int unsigned kbd_fill();
    return (wr_idx + FIFO_DEPTH - rd_idx) % FIFO_DEPTH;
  endfunction

  // Push one character; drop it silently when the ring is full.
  function automatic void kbd_push(input logic [7:0] ch);
    if ((wr_idx + 1) % FIFO_DEPTH != rd_idx) begin
      kbd_mem[wr_idx] = ch;
      wr_idx = (wr_idx + 1) % FIFO_DEPTH;
    end else begin
      dropped_cnt++;
    end
  endfunction

  // Advance the keyboard model by one request and return its result.
  function automatic char_rsp_t kbd_response(input logic [1:0] kind, input logic [7:0] code);
    char_rsp_t  rsp;
    logic [6:0] key;
    logic [7:0] ch;
    logic       rel;
    rsp = IDLE_RSP;
    key = code[6:0];
    rel = code[7];
    case (kind)
      scta_pkg::REQ_SCAN: begin
        if (key == SC_LSHIFT || key == SC_RSHIFT) begin
          shift_dn = !rel;
        end else if (key == SC_CTRL) begin
          ctrl_dn = !rel;
        end else if (!rel) begin
          if (key == SC_CAPS) begin
            caps_tog = !caps_tog;
          end else if (ctrl_dn && key == SC_C) begin
            brk_flag = 1'b1;
            kbd_push(BREAK_CHAR);
          end else if (key < TBL_LEN) begin
            ch = (shift_dn != caps_tog) ? shifted_keys[key] : plain_keys[key];
            if (ch != 8'h00) kbd_push(ch);
          end
        end
      end
      scta_pkg::REQ_POP: begin
        if (wr_idx != rd_idx) begin
          rsp.char_valid = 1'b1;
          rsp.char_code  = kbd_mem[rd_idx];
          rd_idx = (rd_idx + 1) % FIFO_DEPTH;
          popped_cnt++;
        end else begin
          empty_pop_cnt++;
        end
      end
      scta_pkg::REQ_FLAG: begin
        rsp.break_seen = brk_flag;
        if (brk_flag) breaks_read_cnt++;
        brk_flag = 1'b0;
      end
      default: ;
    endcase
    rsp.fill_level = (kbd_fill() > 255) ? 8'hFF : 8'(kbd_fill());
    return rsp;
  endfunction

  // Random key number that types a character in either table.
  function automatic logic [6:0] pick_typed_key();
    logic [6:0] key;
    key = 7'($urandom_range(1, TBL_LEN - 1));
    while (plain_keys[key] == 8'h00) key = 7'($urandom_range(1, TBL_LEN - 1));
    return key;
  endfunction

  // Issue one request. Called at a falling edge; returns at the falling
  // edge after the handshake, with valid still high so that back-to-back
  // requests keep it asserted.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] code,
                          input bit typed = 1'b0, input char_rsp_t typed_rsp = IDLE_RSP);
    char_rsp_t predicted;
    // Switch between gappy and dense stretches every few dozen requests.
    if (gap_run == 0) begin
      src_gappy = ($urandom_range(0, 2) != 0);
      gap_run   = $urandom_range(30, 80);
    end
    gap_run--;
    if (src_gappy && !quiet_tail && $urandom_range(0, 5) == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_bus.valid     = 1'b1;
    req_bus.req_type  = kind;
    req_bus.scan_code = code;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    // Accepted at this edge: predict now, before the block can answer.
    predicted = kbd_response(kind, code);
    kbd_rsp_due.push_back(typed ? typed_rsp : predicted);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Hold the request channel idle until every owed result has come back.
  task automatic drain_wait();
    req_bus.valid = 1'b0;
    while (kbd_rsp_due.size() != 0) @(negedge clk_i);
  endtask

  // One keystroke as a real keyboard sends it: optional modifiers, the
  // key press, usually its release, then usually the modifiers released.
  task automatic type_key();
    logic [6:0] key, shift_key;
    bit         with_shift, with_ctrl;
    with_shift = ($urandom_range(0, 9) < 3);
    with_ctrl  = ($urandom_range(0, 9) == 0);
    shift_key  = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
    if ($urandom_range(0, 9) == 0) begin
      send_req(scta_pkg::REQ_SCAN, {1'b0, SC_CAPS});
      send_req(scta_pkg::REQ_SCAN, {1'b1, SC_CAPS});
    end
    if (with_shift) send_req(scta_pkg::REQ_SCAN, {1'b0, shift_key});
    if (with_ctrl) send_req(scta_pkg::REQ_SCAN, {1'b0, SC_CTRL});
    if (with_ctrl && $urandom_range(0, 1) == 0) key = SC_C;
    else if ($urandom_range(0, 9) == 0) key = 7'($urandom_range(0, 127));
    else key = pick_typed_key();
    send_req(scta_pkg::REQ_SCAN, {1'b0, key});
    if ($urandom_range(0, 9) < 7) send_req(scta_pkg::REQ_SCAN, {1'b1, key});
    // Now and then leave a modifier stuck down.
    if (with_ctrl && $urandom_range(0, 9) != 0)
      send_req(scta_pkg::REQ_SCAN, {1'b1, SC_CTRL});
    if (with_shift && $urandom_range(0, 9) != 0)
      send_req(scta_pkg::REQ_SCAN, {1'b1, shift_key});
  endtask

  // Mixed traffic: pops at the given percentage, some flag reads and raw
  // noise (any request type, any byte), the rest well-formed keystrokes.
  task automatic mixed_req(input int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < pop_pct) send_req(scta_pkg::REQ_POP, 8'($urandom_range(0, 255)));
    else if (roll < pop_pct + 5) send_req(scta_pkg::REQ_FLAG, 8'($urandom_range(0, 255)));
    else if (roll < pop_pct + 10)
      send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    else type_key();
  endtask

  // Result side: stall in random bursts, alternating busy and quiet
  // stretches, and never in the tail of the run.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      sink_stalls = ($urandom_range(0, 2) != 0);
      mode_left   = $urandom_range(40, 160);
    end else begin
      mode_left--;
    end
    if (quiet_tail) hold_left = 0;
    else if (hold_left == 0 && sink_stalls && $urandom_range(0, 5) == 0)
      hold_left = $urandom_range(1, 14);
    if (hold_left != 0) begin
      rsp_bus.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_bus.ready = 1'b1;
    end
  end

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk_i) begin
    char_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (kbd_rsp_due.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
          $display("%0t: unrequested result v=%0b c=%02h b=%0b f=%0d",
                   $time, rsp_bus.char_valid, rsp_bus.char_code, rsp_bus.break_seen,
                   rsp_bus.fill_level);
      end else begin
        want = kbd_rsp_due.pop_front();
        if (rsp_bus.char_valid !== want.char_valid || rsp_bus.char_code !== want.char_code ||
            rsp_bus.break_seen !== want.break_seen || rsp_bus.fill_level !== want.fill_level) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS)
            $display("%0t: exp v=%0b c=%02h b=%0b f=%0d got v=%0b c=%02h b=%0b f=%0d",
                     $time, want.char_valid, want.char_code, want.break_seen, want.fill_level,
                     rsp_bus.char_valid, rsp_bus.char_code, rsp_bus.break_seen,
                     rsp_bus.fill_level);
        end
      end
    end
  end

  // Watchdog: end the run if the block stops moving.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_cnt, kbd_rsp_due.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    // Drive every input known from time zero and hold reset.
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = scta_pkg::REQ_SCAN;
    req_bus.scan_code = 8'h00;
    rsp_bus.ready     = 1'b1;
    wr_idx = 0; rd_idx = 0;
    shift_dn = 1'b0; caps_tog = 1'b0; ctrl_dn = 1'b0; brk_flag = 1'b0;
    sent_cnt = 0; fault_cnt = 0; cycle_cnt = 0;
    popped_cnt = 0; empty_pop_cnt = 0; dropped_cnt = 0; breaks_read_cnt = 0;
    gap_run = 0; hold_left = 0; mode_left = 0;
    src_gappy = 1'b0; sink_stalls = 1'b0; quiet_tail = 1'b0;
    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: reset state, every request type, modifier corners.
    foreach (DIRECTED_ROWS[i])
      send_req(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].code,
               DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

    // Typing with modest pops keeps the FIFO shallow and hits empty pops.
    while (sent_cnt < 60) mixed_req(25);

    // Pause until the block is drained, then fill the FIFO to the brim
    // with no pops so that later presses are dropped.
    drain_wait();
    send_req(scta_pkg::REQ_SCAN, {1'b1, SC_CTRL});
    while (kbd_fill() < FIFO_DEPTH - 1) begin
      if ($urandom_range(0, 9) == 0)
        send_req(scta_pkg::REQ_SCAN, {1'($urandom_range(0, 1)), SC_LSHIFT});
      else
        send_req(scta_pkg::REQ_SCAN, {1'b0, pick_typed_key()});
    end
    repeat (6) send_req(scta_pkg::REQ_SCAN, {1'b0, pick_typed_key()});
    // Ctrl+C on a full FIFO still raises the flag.
    send_req(scta_pkg::REQ_SCAN, {1'b0, SC_CTRL});
    send_req(scta_pkg::REQ_SCAN, {1'b0, SC_C});
    send_req(scta_pkg::REQ_SCAN, {1'b1, SC_CTRL});
    send_req(scta_pkg::REQ_FLAG, 8'h00);

    // Drain with mostly pops, then a quiet tail with no idling at all.
    drain_wait();
    while (kbd_fill() != 0 && sent_cnt < 800) mixed_req(85);
    quiet_tail = 1'b1;
    repeat (25) mixed_req(40);
    req_bus.valid = 1'b0;

    while (kbd_rsp_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("%0d requests: %0d characters popped, %0d pops on empty, %0d breaks read",
             sent_cnt, popped_cnt, empty_pop_cnt, breaks_read_cnt);
    $display("%0d characters dropped on a full FIFO, %0d failures, %0d cycles",
             dropped_cnt, fault_cnt, cycle_cnt);
    if (fault_cnt == 0 && kbd_rsp_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/scta_pkg.sv
hdl/scta_if.sv
hdl/scta_keymap.sv
hdl/scta_store.sv
hdl/scancode_to_ascii_fifo.sv
hdl/scta_checker.sv
tb/testbench.sv
